### design/tpvs_pkg.sv
// Package for the tissue partial-volume split block: payload structs,
// label and mode codes, register indexes. No dependencies.
`default_nettype none
package tpvs_pkg;

    localparam int INTENSITY_BITS_DEF   = 16;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int CFG_IDX_BITS         = 2;
    localparam int CFG_DATA_BITS        = INTENSITY_BITS_DEF;

    localparam logic [1:0] REG_MEAN_CSF   = 2'd0;
    localparam logic [1:0] REG_MEAN_GM    = 2'd1;
    localparam logic [1:0] REG_MEAN_WM    = 2'd2;
    localparam logic [1:0] REG_LABEL_MODE = 2'd3;

    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_PV     = 2'd1;
    localparam logic [1:0] MODE_ARGMAX = 2'd2;

    localparam logic [7:0] LAB_BG     = 8'd0;
    localparam logic [7:0] LAB_CSF    = 8'd1;
    localparam logic [7:0] LAB_GM_CSF = 8'd2;
    localparam logic [7:0] LAB_GM     = 8'd3;
    localparam logic [7:0] LAB_WM_GM  = 8'd4;
    localparam logic [7:0] LAB_WM     = 8'd5;

    typedef struct packed {
        logic [7:0]                    tissue_label;
        logic [INTENSITY_BITS_DEF-1:0] intensity;
    } voxel_t;

    typedef struct packed {
        logic [7:0] prob_csf;
        logic [7:0] prob_gm;
        logic [7:0] prob_wm;
        logic [7:0] label_out;
    } result_t;

endpackage
`default_nettype wire

### design/tissue_partial_volume_split.sv
// Top level of the tissue partial-volume split block.
// Depends on tpvs_pkg and tpvs_divider.
`default_nettype none
// Usage:
//   A voxel word (label, intensity) is taken at each rising edge with start
//   high and busy low. busy is tied low: one voxel per clock, always.
//   Each result word appears on result for one cycle with done high; the
//   receiver cannot stall, so nothing is held back.
//   Pipeline: one stage to form numerator and divisor, one divider stage
//   per quotient bit, then a multiply stage, a rounding/label stage and the
//   argmax output register. Throughput is one word a clock.
//   Configuration: cfg_we with cfg_index/cfg_data writes a register at once;
//   indexes 0..2 are the class means, 3 the label mode. Write only idle.
//   Reset clears the registers (means zero, mode keep) and all valid bits.
//   Mixed labels: w = (x - lo)/(hi - lo) clamped to 0..1, handled with
//   magnitudes so means in either order work; equal means give w = 1 when
//   x is above them. Labels above 5 act as background; argmax labels them 1.
module tissue_partial_volume_split #(
    parameter int WEIGHT_FRAC_BITS = tpvs_pkg::WEIGHT_FRAC_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire tpvs_pkg::voxel_t      voxel,
    output logic                       done,
    output tpvs_pkg::result_t          result,
    input  wire logic                  cfg_we,
    input  wire logic [tpvs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [tpvs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    localparam int IB = tpvs_pkg::INTENSITY_BITS_DEF;
    localparam int F  = WEIGHT_FRAC_BITS;
    localparam int WB = F + 1;          // weight 0..ONE
    localparam int PB = F + 10;         // 255*ONE plus margin
    localparam logic [WB-1:0] ONE = WB'(1) << F;

    // tag carried through the divider: label, mode, saturated weight info
    typedef struct packed {
        logic [7:0] lab;
        logic [1:0] mode;
        logic       sat;     // w fixed without division
        logic       sat_one; // fixed value is ONE (else 0)
    } tag_t;

    logic [IB-1:0] mean_csf_reg, mean_gm_reg, mean_wm_reg;
    logic [1:0]    mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_csf_reg <= '0;
            mean_gm_reg  <= '0;
            mean_wm_reg  <= '0;
            mode_reg     <= tpvs_pkg::MODE_KEEP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tpvs_pkg::REG_MEAN_CSF:   mean_csf_reg <= IB'(cfg_data);
                tpvs_pkg::REG_MEAN_GM:    mean_gm_reg  <= IB'(cfg_data);
                tpvs_pkg::REG_MEAN_WM:    mean_wm_reg  <= IB'(cfg_data);
                tpvs_pkg::REG_LABEL_MODE: mode_reg     <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;
    wire acc = start;

    // ---- stage 1: pick means, form magnitudes, decide saturation ----
    logic [IB-1:0] x, lo, hi, n_c, d_c;
    logic          sat_c, one_c;
    always_comb
    begin
        x  = IB'(voxel.intensity);
        lo = (voxel.tissue_label == tpvs_pkg::LAB_WM_GM) ? mean_gm_reg : mean_csf_reg;
        hi = (voxel.tissue_label == tpvs_pkg::LAB_WM_GM) ? mean_wm_reg : mean_gm_reg;
        n_c   = '0;
        d_c   = '1;
        sat_c = 1'b1;
        one_c = 1'b0;
        if (hi == lo)
            one_c = x > lo;
        else if (hi > lo)
        begin
            n_c = x - lo;
            d_c = hi - lo;
            if (x <= lo)          one_c = 1'b0;
            else if (n_c >= d_c)  one_c = 1'b1;
            else                  sat_c = 1'b0;
        end
        else
        begin
            n_c = lo - x;
            d_c = lo - hi;
            if (x >= lo)          one_c = 1'b0;
            else if (n_c >= d_c)  one_c = 1'b1;
            else                  sat_c = 1'b0;
        end
    end

    logic          v1_reg;
    logic [IB-1:0] n1_reg, d1_reg;
    tag_t          t1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= acc;
    end
    always_ff @(posedge clk)
    begin
        // saturated words divide 0/1-ish dummy; quotient ignored
        n1_reg <= sat_c ? '0 : n_c;
        d1_reg <= sat_c ? {{(IB-1){1'b0}}, 1'b1} : d_c;
        t1_reg <= '{lab: voxel.tissue_label, mode: mode_reg, sat: sat_c, sat_one: one_c};
    end

    // ---- divider stages ----
    logic          v2;
    logic [F-1:0]  q2;
    tag_t          t2;
    tpvs_divider #(.NB(IB), .QB(F), .TAG($bits(tag_t))) u_div (
        .clk(clk), .rst_n(rst_n), .in_valid(v1_reg), .num(n1_reg), .den(d1_reg),
        .in_tag(t1_reg), .out_valid(v2), .quo(q2), .out_tag(t2)
    );

    // ---- stage 3: products ----
    logic [WB-1:0] w;
    assign w = t2.sat ? (t2.sat_one ? ONE : '0) : {1'b0, q2};

    logic          v3_reg;
    logic [PB-1:0] plo_reg, phi_reg, ppv_reg;
    tag_t          t3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2;
    end
    always_ff @(posedge clk)
    begin
        plo_reg <= PB'(ONE - w) * PB'(255);
        phi_reg <= PB'(w) * PB'(255);
        ppv_reg <= (PB'(w) + ((t2.lab == tpvs_pkg::LAB_WM_GM) ? PB'(2) * PB'(ONE)
                                                               : PB'(ONE))) * PB'(85);
        t3_reg  <= t2;
    end

    // ---- stage 4: round, place channels, pv label ----
    localparam logic [PB-1:0] HALF = PB'(ONE >> 1);
    logic [7:0] rlo, rhi, rpv;
    assign rlo = 8'((plo_reg + HALF) >> F);
    assign rhi = 8'((phi_reg + HALF) >> F);
    assign rpv = 8'((ppv_reg + HALF) >> F);

    tpvs_pkg::result_t r4_c;
    logic pv_c;
    logic [7:0] rpv_sel;
    always_comb
    begin
        r4_c = '0;
        r4_c.label_out = t3_reg.lab;
        pv_c = 1'b1;
        unique case (t3_reg.lab)
            tpvs_pkg::LAB_CSF:    begin r4_c.prob_csf = 8'd255; rpv_sel = 8'd85; end
            tpvs_pkg::LAB_GM_CSF: begin r4_c.prob_csf = rlo; r4_c.prob_gm = rhi;
                                        rpv_sel = rpv; end
            tpvs_pkg::LAB_GM:     begin r4_c.prob_gm = 8'd255; rpv_sel = 8'd170; end
            tpvs_pkg::LAB_WM_GM:  begin r4_c.prob_gm = rlo; r4_c.prob_wm = rhi;
                                        rpv_sel = rpv; end
            tpvs_pkg::LAB_WM:     begin r4_c.prob_wm = 8'd255; rpv_sel = 8'd255; end
            default:              begin pv_c = 1'b0; rpv_sel = 8'd0; end
        endcase
        if (t3_reg.mode == tpvs_pkg::MODE_PV && pv_c)
            r4_c.label_out = rpv_sel;
    end

    logic              v4_reg;
    tpvs_pkg::result_t r4_reg;
    logic              am4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        r4_reg  <= r4_c;
        am4_reg <= (t3_reg.mode == tpvs_pkg::MODE_ARGMAX) && (t3_reg.lab != tpvs_pkg::LAB_BG);
    end

    // ---- stage 5: argmax, first channel wins ties ----
    tpvs_pkg::result_t r5_c;
    always_comb
    begin
        r5_c = r4_reg;
        if (am4_reg)
        begin
            priority if (r4_reg.prob_wm > r4_reg.prob_csf && r4_reg.prob_wm > r4_reg.prob_gm)
                r5_c.label_out = 8'd3;
            else if (r4_reg.prob_gm > r4_reg.prob_csf)
                r5_c.label_out = 8'd2;
            else
                r5_c.label_out = 8'd1;
        end
    end

    logic              done_reg;
    tpvs_pkg::result_t result_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done_reg <= 1'b0;
        else        done_reg <= v4_reg;
    end
    always_ff @(posedge clk)
        result_reg <= r5_c;

    assign done   = done_reg;
    assign result = result_reg;

    // ---- checks ----
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |=> ##1 done) else $error("pipeline dropped a word");
    // a weight of exactly one half rounds both channels up to 128
    a_mix_sum: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.prob_wm == 8'd0 && result.prob_csf != 8'd0 && result.prob_gm != 8'd0
        |-> (9'(result.prob_csf) + 9'(result.prob_gm) == 9'd255)
            || (9'(result.prob_csf) + 9'(result.prob_gm) == 9'd256))
        else $error("mixed channels do not split 255");
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy) else $error("busy raised");
endmodule
`default_nettype wire

### design/tpvs_divider.sv
// Pipelined restoring divider: one quotient bit per stage, n < d assumed.
// Depends on nothing; carries a tag alongside the data.
`default_nettype none
module tpvs_divider #(
    parameter int NB  = 16,
    parameter int QB  = 16,
    parameter int TAG = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  wire logic [NB-1:0]  num,
    input  wire logic [NB-1:0]  den,
    input  wire logic [TAG-1:0] in_tag,
    output logic                out_valid,
    output logic [QB-1:0]       quo,
    output logic [TAG-1:0]      out_tag
);
    // remainder stays below den, so NB+1 bits suffice for the shifted value
    logic [QB:0]     vld_reg;
    logic [NB-1:0]   rem_reg [QB+1];
    logic [NB-1:0]   den_reg [QB+1];
    logic [QB-1:0]   q_reg   [QB+1];
    logic [TAG-1:0]  tag_reg [QB+1];

    always_comb
    begin
        vld_reg[0] = in_valid;
        rem_reg[0] = num;
        den_reg[0] = den;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
    end

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic [NB:0] sh;
        logic        ge;
        assign sh = {rem_reg[s], 1'b0};
        assign ge = sh >= {1'b0, den_reg[s]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else
                vld_reg[s+1] <= vld_reg[s];
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s+1] <= ge ? NB'(sh - {1'b0, den_reg[s]}) : sh[NB-1:0];
            den_reg[s+1] <= den_reg[s];
            q_reg[s+1]   <= {q_reg[s][QB-2:0], ge};
            tag_reg[s+1] <= tag_reg[s];
        end
    end

    assign out_valid = vld_reg[QB];
    assign quo       = q_reg[QB];
    assign out_tag   = tag_reg[QB];
endmodule
`default_nettype wire

### dv/tpvs_checker.sv
// Scoreboard for tissue_partial_volume_split: watches the voxel, result and
// register ports, predicts each result word and compares it. Uses tpvs_pkg.
module tpvs_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  tpvs_pkg::voxel_t                   voxel,
    input  logic                               done,
    input  tpvs_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [tpvs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [tpvs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                 mismatches,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [16:0] W_ONE  = 17'h10000;
    localparam logic [31:0] W_HALF = 32'h8000;

    logic [15:0] avg_csf, avg_gm, avg_wm;
    logic [1:0]  lab_mode;
    tpvs_pkg::result_t split_q[$];

    // clamped mix weight, 16 fractional bits
    function automatic logic [16:0] mix_fraction(logic [15:0] x, logic [15:0] lo,
                                                 logic [15:0] hi);
        logic [16:0] n, d;
        logic [32:0] q;
        if (hi == lo)
            return (x > lo) ? W_ONE : 17'd0;
        if (hi > lo)
        begin
            if (x <= lo)
                return 17'd0;
            n = x - lo;
            d = hi - lo;
        end
        else
        begin
            if (x >= lo)
                return 17'd0;
            n = lo - x;
            d = lo - hi;
        end
        if (n >= d)
            return W_ONE;
        q = {n, 16'd0} / d;
        return q[16:0];
    endfunction

    function automatic logic [7:0] scale_round(logic [7:0] k, logic [17:0] w);
        logic [31:0] p;
        p = k * w + W_HALF;
        return p[23:16];
    endfunction

    function automatic tpvs_pkg::result_t split_voxel(tpvs_pkg::voxel_t v);
        tpvs_pkg::result_t r;
        logic [16:0] w;
        logic [7:0]  pv;
        logic [7:0]  ch[3];
        bit          has_pv;
        int          best;
        ch = '{8'd0, 8'd0, 8'd0};
        pv = 8'd0;
        has_pv = 1'b1;
        case (v.tissue_label)
            tpvs_pkg::LAB_CSF:
            begin
                ch[0] = 8'd255;
                pv = 8'd85;
            end
            tpvs_pkg::LAB_GM_CSF:
            begin
                w = mix_fraction(v.intensity, avg_csf, avg_gm);
                ch[0] = scale_round(8'd255, W_ONE - w);
                ch[1] = scale_round(8'd255, w);
                pv = scale_round(8'd85, W_ONE + w);
            end
            tpvs_pkg::LAB_GM:
            begin
                ch[1] = 8'd255;
                pv = 8'd170;
            end
            tpvs_pkg::LAB_WM_GM:
            begin
                w = mix_fraction(v.intensity, avg_gm, avg_wm);
                ch[1] = scale_round(8'd255, W_ONE - w);
                ch[2] = scale_round(8'd255, w);
                pv = scale_round(8'd85, {W_ONE, 1'b0} + w);
            end
            tpvs_pkg::LAB_WM:
            begin
                ch[2] = 8'd255;
                pv = 8'd255;
            end
            default: has_pv = 1'b0;
        endcase
        r.label_out = v.tissue_label;
        if (lab_mode == tpvs_pkg::MODE_PV && has_pv)
            r.label_out = pv;
        else if (lab_mode == tpvs_pkg::MODE_ARGMAX && v.tissue_label != tpvs_pkg::LAB_BG)
        begin
            best = 0;
            if (ch[1] > ch[best])
                best = 1;
            if (ch[2] > ch[best])
                best = 2;
            r.label_out = 8'(best + 1);
        end
        r.prob_csf = ch[0];
        r.prob_gm = ch[1];
        r.prob_wm = ch[2];
        return r;
    endfunction

    assign pending = split_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        tpvs_pkg::result_t want;
        if (!rst_n)
        begin
            avg_csf <= '0;
            avg_gm <= '0;
            avg_wm <= '0;
            lab_mode <= tpvs_pkg::MODE_KEEP;
            mismatches <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tpvs_pkg::REG_MEAN_CSF:   avg_csf <= cfg_data;
                    tpvs_pkg::REG_MEAN_GM:    avg_gm <= cfg_data;
                    tpvs_pkg::REG_MEAN_WM:    avg_wm <= cfg_data;
                    tpvs_pkg::REG_LABEL_MODE: lab_mode <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (split_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result word %h", result);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = split_q.pop_front();
                    if (want !== result)
                    begin
                        if (mismatches < 10)
                            $display("expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                     want.prob_csf, want.prob_gm, want.prob_wm, want.label_out,
                                     result.prob_csf, result.prob_gm, result.prob_wm,
                                     result.label_out);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            // config only moves when idle, so the current copy applies
            if (start && !busy)
                split_q.push_back(split_voxel(voxel));
        end
    end
endmodule

### dv/tissue_partial_volume_split_tb.sv
// Testbench top for tissue_partial_volume_split: drives voxel words and
// register writes, verdict from tpvs_checker. Uses tpvs_pkg and the RTL.
module tissue_partial_volume_split_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 28;       // pipeline is 20 deep at the defaults
    localparam int LIMIT  = 200000;

    logic clk, rst_n, start, busy, done, cfg_we;
    tpvs_pkg::voxel_t  voxel;
    tpvs_pkg::result_t result;
    logic [tpvs_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [tpvs_pkg::CFG_DATA_BITS-1:0] cfg_data;
    int mismatches, pending, cycles;
    bit no_gaps;
    logic [15:0] lo_sel, hi_sel;

    tissue_partial_volume_split dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .voxel(voxel),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tpvs_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .voxel(voxel),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // register write, one cycle of cfg_we
    task automatic write_reg(logic [tpvs_pkg::CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_means(logic [15:0] c, logic [15:0] g, logic [15:0] w,
                             logic [1:0] m);
        write_reg(tpvs_pkg::REG_MEAN_CSF, c);
        write_reg(tpvs_pkg::REG_MEAN_GM, g);
        write_reg(tpvs_pkg::REG_MEAN_WM, w);
        write_reg(tpvs_pkg::REG_LABEL_MODE, 16'(m));
    endtask

    // word goes out at a falling edge; busy is stable from there to the
    // next rising edge, so it tells whether that edge takes the word
    task automatic send_voxel(logic [7:0] lab, logic [15:0] x);
        bit stalled;
        while (!no_gaps && $urandom_range(99) < 13)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        voxel <= '{tissue_label: lab, intensity: x};
        stalled = busy;
        @(posedge clk);
        while (stalled)
        begin
            @(negedge clk);
            stalled = busy;
            @(posedge clk);
        end
    endtask

    // let the pipe empty before touching registers
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // mostly labels 0..5, intensities mostly between the two means in use
    task automatic random_voxels(int count);
        logic [7:0]  lab;
        logic [15:0] x, a, b;
        int pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                lab = 8'($urandom_range(6, 255));
            else
                lab = 8'($urandom_range(0, 5));
            a = (lab == tpvs_pkg::LAB_WM_GM) ? u_checker.avg_gm : u_checker.avg_csf;
            b = (lab == tpvs_pkg::LAB_WM_GM) ? u_checker.avg_wm : u_checker.avg_gm;
            if (a > b)
            begin
                x = a;
                a = b;
                b = x;
            end
            if ($urandom_range(99) < 25)
                x = 16'($urandom);
            else if ($urandom_range(99) < 10)
                x = ($urandom_range(1)) ? a : b;
            else
                x = 16'($urandom_range(a, b));
            send_voxel(lab, x);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        voxel = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        no_gaps = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every label, extreme intensities, both mixes
        set_means(16'd1000, 16'd3000, 16'd5000, tpvs_pkg::MODE_PV);
        for (int l = 0; l <= 7; l++)
            send_voxel(8'(l), 16'd2000);
        send_voxel(8'd255, 16'hFFFF);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'd0);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'hFFFF);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'd1000);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'd3000);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'd1001);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'd0);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'hFFFF);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'd4000);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'd4999);
        drain();

        // argmax with ties at the midpoint
        set_means(16'd0, 16'd2, 16'd4, tpvs_pkg::MODE_ARGMAX);
        for (int l = 0; l <= 6; l++)
            send_voxel(8'(l), 16'd1);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'd3);
        drain();

        // equal means: zero divisor
        set_means(16'd500, 16'd500, 16'd500, tpvs_pkg::MODE_PV);
        random_voxels(150);
        send_voxel(tpvs_pkg::LAB_GM_CSF, 16'd500);
        send_voxel(tpvs_pkg::LAB_WM_GM, 16'd501);
        drain();

        // long stretch with no gaps, mixed means, keep label
        no_gaps = 1'b1;
        set_means(16'd2000, 16'd30000, 16'd60000, tpvs_pkg::MODE_KEEP);
        random_voxels(300);
        no_gaps = 1'b0;
        drain();

        // descending means, extremes of the register range
        set_means(16'hFFFF, 16'h8000, 16'd0, tpvs_pkg::MODE_PV);
        random_voxels(300);
        drain();

        // undefined mode acts as keep
        set_means(16'd100, 16'd40000, 16'd41000, 2'd3);
        random_voxels(150);
        drain();

        set_means(16'($urandom), 16'($urandom), 16'($urandom), tpvs_pkg::MODE_ARGMAX);
        random_voxels(300);
        drain();

        // narrow spans so weights land on coarse steps
        lo_sel = 16'($urandom_range(0, 60000));
        hi_sel = lo_sel + 16'($urandom_range(1, 9));
        set_means(lo_sel, hi_sel, hi_sel + 16'd3, tpvs_pkg::MODE_PV);
        random_voxels(300);
        drain();

        set_means(16'($urandom), 16'($urandom), 16'($urandom), tpvs_pkg::MODE_PV);
        random_voxels(300);
        drain();

        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

### sim.f
design/tpvs_pkg.sv
design/tpvs_divider.sv
design/tissue_partial_volume_split.sv
dv/tpvs_checker.sv
dv/tissue_partial_volume_split_tb.sv
